// ===== rtl/rks_pkg.sv =====
`default_nettype none
package rks_pkg;

  // default depth of the value store
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned STATUS_W     = 2;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE     = 2'd0,
    S_INS_CHK  = 2'd1,
    S_INS_CMP  = 2'd2,
    S_GET_WAIT = 2'd3
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;     // latch value, start position at fill count
    logic ins_read;   // read entry just below the insert position
    logic ins_shift;  // move read entry up one slot, step position down
    logic ins_place;  // write new value at position, bump fill count
    logic get_read;   // read entry at query rank
    logic get_load;   // load read entry as result, bump query count
    logic out_full;   // load store-full result
    logic out_short;  // load too-few-values result
    logic do_clear;   // empty store and zero query count
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic pos_zero;
    logic shift_more;
    logic get_ok;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/rks_ram.sv =====
`default_nettype none
module rks_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/rks_ctrl.sv =====
`default_nettype none
module rks_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [rks_pkg::REQ_W-1:0]    req_type,
  input  wire rks_pkg::stat_t               stat,
  output rks_pkg::cmd_t                     cmd
);

  rks_pkg::state_t state, state_next;
  logic            take;

  assign take = (state == rks_pkg::S_IDLE) && !stat.out_busy && in_valid;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rks_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rks_pkg::S_IDLE: begin
        if (take) begin
          case (req_type)
            rks_pkg::REQ_ADD: begin
              if (!stat.full) state_next = rks_pkg::S_INS_CHK;
            end
            rks_pkg::REQ_GET: begin
              if (stat.get_ok) state_next = rks_pkg::S_GET_WAIT;
            end
            default: state_next = rks_pkg::S_IDLE;
          endcase
        end
      end
      rks_pkg::S_INS_CHK: begin
        state_next = stat.pos_zero ? rks_pkg::S_IDLE : rks_pkg::S_INS_CMP;
      end
      rks_pkg::S_INS_CMP: begin
        state_next = stat.shift_more ? rks_pkg::S_INS_CHK : rks_pkg::S_IDLE;
      end
      rks_pkg::S_GET_WAIT: begin
        state_next = rks_pkg::S_IDLE;
      end
      default: state_next = rks_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = !((state == rks_pkg::S_IDLE) && !stat.out_busy);
    case (state)
      rks_pkg::S_IDLE: begin
        if (take) begin
          case (req_type)
            rks_pkg::REQ_ADD: begin
              if (stat.full) cmd.out_full = 1'b1;
              else           cmd.accept   = 1'b1;
            end
            rks_pkg::REQ_GET: begin
              if (stat.get_ok) cmd.get_read  = 1'b1;
              else             cmd.out_short = 1'b1;
            end
            rks_pkg::REQ_CLEAR: begin
              cmd.do_clear = 1'b1;
            end
            default: cmd = '0;
          endcase
        end
      end
      rks_pkg::S_INS_CHK: begin
        if (stat.pos_zero) cmd.ins_place = 1'b1;
        else               cmd.ins_read  = 1'b1;
      end
      rks_pkg::S_INS_CMP: begin
        if (stat.shift_more) cmd.ins_shift = 1'b1;
        else                 cmd.ins_place = 1'b1;
      end
      rks_pkg::S_GET_WAIT: begin
        cmd.get_load = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/rks_dpath.sv =====
`default_nettype none
module rks_dpath #(
  parameter int unsigned CAPACITY = rks_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic signed [rks_pkg::VALUE_W-1:0]  value,
  input  wire rks_pkg::cmd_t                       cmd,
  output rks_pkg::stat_t                           stat,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [rks_pkg::VALUE_W-1:0]       kth_value,
  output logic        [rks_pkg::STATUS_W-1:0]      status
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [rks_pkg::VALUE_W-1:0] val_reg;
  logic        [CW-1:0]               pos;
  logic        [CW-1:0]               count;
  logic        [CW-1:0]               gets;
  logic        [CW-1:0]               pos_m1;
  logic                               we;
  logic        [AW-1:0]               waddr;
  logic        [AW-1:0]               raddr;
  logic        [rks_pkg::VALUE_W-1:0] wdata;
  logic        [rks_pkg::VALUE_W-1:0] rdata;

  assign pos_m1 = pos - CW'(1);

  // memory port steering
  assign we    = cmd.ins_shift || cmd.ins_place;
  assign waddr = pos[AW-1:0];
  assign wdata = cmd.ins_shift ? rdata : val_reg;
  assign raddr = cmd.ins_read ? pos_m1[AW-1:0] : gets[AW-1:0];

  rks_ram #(
    .WIDTH (rks_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status toward the controller
  always_comb begin
    stat.full       = (count == CW'(CAPACITY));
    stat.pos_zero   = (pos == '0);
    stat.shift_more = ($signed(rdata) > val_reg);
    stat.get_ok     = (gets < count);
    stat.out_busy   = out_valid && out_stall;
  end

  // insert value and position
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_reg <= value;
      pos     <= count;
    end else if (cmd.ins_shift) begin
      pos     <= pos_m1;
    end
  end

  // fill count and query count
  always_ff @(posedge clk) begin
    if (rst || cmd.do_clear) begin
      count <= '0;
      gets  <= '0;
    end else begin
      if (cmd.ins_place) count <= count + CW'(1);
      if (cmd.get_load)  gets  <= gets + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.get_load || cmd.out_full || cmd.out_short) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.get_load) begin
      kth_value <= $signed(rdata);
      status    <= rks_pkg::ST_OK;
    end else if (cmd.out_full) begin
      kth_value <= '0;
      status    <= rks_pkg::ST_FULL;
    end else if (cmd.out_short) begin
      kth_value <= '0;
      status    <= rks_pkg::ST_SHORT;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/running_kth_smallest_store_unit.sv =====
`default_nettype none
// Sorted store of signed values answering running order-statistic queries. An add
// beat inserts its value by walking down from the top of the store one entry at a
// time, each step a read of the block RAM followed by a compare and a shift write,
// until it reaches an entry not greater than the new value or the bottom of the
// store; an add into a full store answers with status 2. A get beat is one RAM
// read with registered data, or answers with status 1 when too few values are
// stored. A clear, or an unused request code, gives no result. The store needs no
// clearing pass after reset. The input is stalled while an item is at work and
// while a result waits in the output register under stall.
module running_kth_smallest_store_unit #(
  parameter int unsigned CAPACITY = rks_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [rks_pkg::REQ_W-1:0]    req_type,
  input  wire logic signed [rks_pkg::VALUE_W-1:0]  value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [rks_pkg::VALUE_W-1:0]       kth_value,
  output logic        [rks_pkg::STATUS_W-1:0]      status
);

  rks_pkg::cmd_t  cmd;
  rks_pkg::stat_t stat;

  rks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd)
  );

  rks_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kth_value (kth_value),
    .status    (status)
  );

endmodule
`default_nettype wire

// ===== rtl/rks_checker.sv =====
`default_nettype none
module rks_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic        [rks_pkg::REQ_W-1:0]    req_type,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [rks_pkg::VALUE_W-1:0]  kth_value,
  input wire logic        [rks_pkg::STATUS_W-1:0] status
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kth_value) && $stable(status))
    else $error("result beat changed under stall");

  // only a successful get carries a value
  a_zero_on_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != rks_pkg::ST_OK) |-> (kth_value == '0))
    else $error("nonzero value on error status");

  // no status code outside the defined ones
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == rks_pkg::ST_OK || status == rks_pkg::ST_SHORT ||
                   status == rks_pkg::ST_FULL))
    else $error("undefined status code");

  // a clear gives no result
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid && (req_type == rks_pkg::REQ_CLEAR)
    |=> !out_valid)
    else $error("result after clear");

  // no new beat taken while a result waits under stall
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

endmodule

bind running_kth_smallest_store_unit rks_checker u_rks_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kth_value (kth_value),
  .status    (status)
);
`default_nettype wire
